/* sv/stis_pkg.sv */
// ============================================================================
// stis_pkg
// Shared types and constants for the sorted table interval search block:
// index width, operation codes, controller states and the command and
// status groups that pass between controller and datapath.
// ============================================================================
package stis_pkg;

    // Width of every table index field on the ports
    localparam int IDX_BITS = 12;

    typedef logic [IDX_BITS-1:0] idx_t;

    // Operation codes of an input item
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_PROBE,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_search;
        logic write_entry;
        logic check_lo;
        logic check_hi;
        logic step;
        logic load_out;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic bad;
        logic step_done;
        logic out_free;
    } dp_status_t;

    // Upward-rounded midpoint of two indexes
    function automatic idx_t mid_up(idx_t lo, idx_t hi);
        logic [IDX_BITS:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} + (IDX_BITS + 1)'(1);
        return sum[IDX_BITS:1];
    endfunction

endpackage

/* sv/stis_if.sv */
// ============================================================================
// stis_req_if / stis_rsp_if
// Valid/ready channels of the interval search block: the request channel
// carries write and search items, the response channel carries results.
// ============================================================================
interface stis_req_if #(
    parameter int RADIUS_BITS = 32
);
    import stis_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    idx_t                   entry_index;
    logic [RADIUS_BITS-1:0] entry_radius;
    idx_t                   lower_index;
    idx_t                   upper_index;
    logic [RADIUS_BITS-1:0] query_radius;

    modport source (
        output valid, operation, entry_index, entry_radius,
               lower_index, upper_index, query_radius,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, entry_radius,
               lower_index, upper_index, query_radius,
        output ready
    );
endinterface

interface stis_rsp_if;
    import stis_pkg::*;

    logic valid;
    logic ready;
    idx_t found_index;
    logic out_of_range;
    logic bad_bounds;

    modport source (
        output valid, found_index, out_of_range, bad_bounds,
        input  ready
    );

    modport sink (
        input  valid, found_index, out_of_range, bad_bounds,
        output ready
    );
endinterface

/* sv/stis_ctrl.sv */
// ============================================================================
// stis_ctrl
// Controller of the interval search: takes items, sequences the bracket
// reads and the bisection probes, and hands the result to the output stage.
// ============================================================================
module stis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_operation,
    output logic                req_ready,
    input  stis_pkg::dp_status_t status,
    output stis_pkg::dp_cmd_t   cmd
);
    import stis_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_operation == OP_SEARCH)
                    begin
                        cmd.load_search = 1'b1;
                        state_next      = ST_CHK_LO;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_CHK_LO:
            begin
                cmd.check_lo = 1'b1;
                state_next   = ST_CHK_HI;
            end
            ST_CHK_HI:
            begin
                cmd.check_hi = 1'b1;
                state_next   = status.bad ? ST_FINISH : ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.step = 1'b1;
                if (status.step_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/stis_datapath.sv */
// ============================================================================
// stis_datapath
// Radius table memory, search bounds, probe address logic, range flag and
// the result register of the interval search.
// ============================================================================
module stis_datapath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int RADIUS_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  stis_pkg::dp_cmd_t       cmd,
    output stis_pkg::dp_status_t    status,
    input  stis_pkg::idx_t          entry_index,
    input  logic [RADIUS_BITS-1:0]  entry_radius,
    input  stis_pkg::idx_t          lower_index,
    input  stis_pkg::idx_t          upper_index,
    input  logic [RADIUS_BITS-1:0]  query_radius,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output stis_pkg::idx_t          found_index,
    output logic                    out_of_range,
    output logic                    bad_bounds
);
    import stis_pkg::*;

    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
    localparam int EXT_BITS  = ((ADDR_BITS > IDX_BITS) ? ADDR_BITS : IDX_BITS) + 1;

    typedef logic [RADIUS_BITS-1:0] radius_t;

    // Index lies inside the table
    function automatic logic in_table(idx_t i);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(i);
        return e < EXT_BITS'(TABLE_DEPTH);
    endfunction

    // Memory address of an index
    function automatic logic [ADDR_BITS-1:0] to_addr(idx_t i);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(i);
        return e[ADDR_BITS-1:0];
    endfunction

    radius_t mem [TABLE_DEPTH];

    radius_t rdata_reg;
    logic    rd_ok_reg;
    idx_t    probe_reg;
    idx_t    lo_reg;
    idx_t    hi_reg;
    radius_t q_reg;
    logic    bad_reg;
    logic    oor_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    idx_t    found_reg;
    logic    out_oor_reg;
    logic    out_bad_reg;

    radius_t rdata_eff;
    logic    rd_lt;
    idx_t    lo_step;
    idx_t    hi_step;
    idx_t    rd_idx;

    // Entries beyond the table read as zero
    assign rdata_eff = rd_ok_reg ? rdata_reg : '0;
    assign rd_lt     = rdata_eff < q_reg;

    // Bisection step on the probe just read
    assign lo_step = rd_lt ? probe_reg : lo_reg;
    assign hi_step = rd_lt ? hi_reg : probe_reg - IDX_BITS'(1);

    // Select the next read address
    always_comb
    begin
        if (cmd.load_search)
        begin
            rd_idx = lower_index;
        end
        else if (cmd.check_lo)
        begin
            rd_idx = hi_reg;
        end
        else if (cmd.check_hi)
        begin
            rd_idx = mid_up(lo_reg, hi_reg);
        end
        else
        begin
            rd_idx = mid_up(lo_step, hi_step);
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && in_table(entry_index))
        begin
            mem[to_addr(entry_index)] <= entry_radius;
        end
        rdata_reg <= mem[to_addr(rd_idx)];
        rd_ok_reg <= in_table(rd_idx);
        probe_reg <= rd_idx;
    end

    // Search bounds and flags
    always_ff @(posedge clk)
    begin
        if (cmd.load_search)
        begin
            lo_reg  <= lower_index;
            hi_reg  <= upper_index;
            q_reg   <= query_radius;
            bad_reg <= !(lower_index < upper_index);
        end
        else if (cmd.step)
        begin
            lo_reg <= lo_step;
            hi_reg <= hi_step;
        end

        if (cmd.check_lo)
        begin
            oor_reg <= (rdata_eff > q_reg) && (lo_reg > IDX_BITS'(1));
        end
        else if (cmd.check_hi)
        begin
            oor_reg <= oor_reg || (rdata_eff < q_reg);
        end
    end

    // Result register: hold until taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            found_reg   <= lo_reg;
            out_oor_reg <= oor_reg;
            out_bad_reg <= bad_reg;
        end
    end

    assign status.bad       = bad_reg;
    assign status.step_done = (lo_step == hi_step);
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid    = out_valid_reg;
    assign found_index  = found_reg;
    assign out_of_range = out_oor_reg;
    assign bad_bounds   = out_bad_reg;

endmodule

/* sv/sorted_table_interval_search.sv */
// ============================================================================
// sorted_table_interval_search
// Table of ascending radii with a bisection search for the largest index
// in a range whose entry lies below a query radius.
// ============================================================================
// Usage:
//   req carries items. A write item (operation 0) stores entry_radius at
//   entry_index and gives no result. A search item (operation 1) gives one
//   result on rsp: found_index, out_of_range and bad_bounds.
//   A search reads the entries at both bounds, then runs one bisection probe
//   per cycle through the single table read port, up to
//   ceil(log2(upper - lower + 1)) probes, then loads the result register.
//   With bad bounds it skips the probes.
//   req.ready is high only while the controller is idle, so searches run
//   one at a time; the next item is taken while a result waits on rsp.
//   When rsp stalls, the result is held; a further finished search waits
//   in the controller until the result register frees.
//   Reset clears the controller and the result valid; the table contents
//   are undefined until written.
// ============================================================================
module sorted_table_interval_search #(
    parameter int TABLE_DEPTH = 4096,
    parameter int RADIUS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    stis_req_if.sink    req,
    stis_rsp_if.source  rsp
);
    import stis_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence each item
    stis_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // Table, bounds and result
    stis_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .entry_index  (req.entry_index),
        .entry_radius (req.entry_radius),
        .lower_index  (req.lower_index),
        .upper_index  (req.upper_index),
        .query_radius (req.query_radius),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .found_index  (rsp.found_index),
        .out_of_range (rsp.out_of_range),
        .bad_bounds   (rsp.bad_bounds)
    );

endmodule

/* sv/stis_checker.sv */
// ============================================================================
// stis_checker
// Port-level checks of the interval search: reset, one search at a time,
// result held under stall, and the result index within the searched range.
// ============================================================================
module stis_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           req_operation,
    input stis_pkg::idx_t req_lower_index,
    input stis_pkg::idx_t req_upper_index,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input stis_pkg::idx_t rsp_found_index,
    input logic           rsp_out_of_range,
    input logic           rsp_bad_bounds
);
    import stis_pkg::*;

    logic search_acc;
    idx_t lo_reg;
    idx_t hi_reg;

    assign search_acc = req_valid && req_ready && (req_operation == OP_SEARCH);

    // Capture the bounds of the last search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (search_acc)
        begin
            lo_reg <= req_lower_index;
            hi_reg <= req_upper_index;
        end
    end

    // No result shows while in reset
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // A search blocks the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        search_acc |=> !req_ready)
        else $error("item taken while a search runs");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_index)
            && $stable(rsp_out_of_range) && $stable(rsp_bad_bounds))
        else $error("stalled result changed");

    // A fresh result lies in the searched range
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> (rsp_bad_bounds && rsp_found_index == lo_reg)
            || (!rsp_bad_bounds && rsp_found_index >= lo_reg
                && rsp_found_index <= hi_reg))
        else $error("result index outside the searched range");

endmodule

bind sorted_table_interval_search stis_checker u_stis_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_operation    (req.operation),
    .req_lower_index  (req.lower_index),
    .req_upper_index  (req.upper_index),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found_index  (rsp.found_index),
    .rsp_out_of_range (rsp.out_of_range),
    .rsp_bad_bounds   (rsp.bad_bounds)
);
